[rtl/prime_sieve_enumerator_defines.svh]
// Assertion helpers for the sieve RTL
`ifndef PRIME_SIEVE_ENUMERATOR_DEFINES_SVH
`define PRIME_SIEVE_ENUMERATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PSE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pse check failed");

// next-cycle implication, checked out of reset
`define PSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pse check failed");

`endif

[rtl/pse_pkg.sv]
`default_nettype none

package pse_pkg;

    localparam int          MAX_LIMIT_DEF = 65536;
    localparam int          LIMIT_W       = 17;
    localparam int          PRIME_W       = 16;
    localparam int          APB_DATA_W    = 32;
    localparam int          APB_ADDR_W    = 3;
    localparam logic [16:0] LIMIT_RST     = 17'd100;

    // register index, taken from paddr[2]
    localparam logic        REG_LIMIT_N   = 1'b0;

endpackage

`default_nettype wire

[rtl/pse_ram.sv]
`default_nettype none

module pse_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/prime_sieve_enumerator.sv]
// Restart: rewrites the bitmap (L = clamped limit), then for each p with p*p < L reads
//   its bit and, when p is prime, strikes its multiples from p*p upward.
// Next-prime request: reads and checks bitmap bits one at a time from the saved scan
//   point; it runs past the returned prime to the following one for tlast.
// One request in flight; the single-port bitmap read and the shared adder set the pace.
// Reset (synchronous, active low) clears control state and sets limit_n to 100.
`default_nettype none

`include "prime_sieve_enumerator_defines.svh"

module prime_sieve_enumerator
    import pse_pkg::*;
#(
    parameter int MAX_LIMIT = MAX_LIMIT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request stream
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [7:0]            i_s_tdata,   // [0] restart
    // result stream
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [15:0]                o_m_tdata,   // [15:0] prime_value
    output logic [0:0]                 o_m_tuser,   // [0] found
    output logic                       o_m_tlast,   // is_last
    // configuration
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic [APB_ADDR_W-1:0] i_paddr,
    input  wire logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0]      o_prdata,
    output logic                       o_pready
);

    localparam int LIM_W  = $clog2(MAX_LIMIT + 1);
    localparam int ADDR_W = $clog2(MAX_LIMIT);
    localparam int SQ_W   = LIM_W + 1;
    localparam int CMP_W  = (LIM_W > LIMIT_W) ? LIM_W : LIMIT_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLR    = 4'd1;
    localparam logic [3:0] S_SV_RD  = 4'd2;
    localparam logic [3:0] S_SV_CHK = 4'd3;
    localparam logic [3:0] S_STRIKE = 4'd4;
    localparam logic [3:0] S_SV_SQ  = 4'd5;
    localparam logic [3:0] S_SV_P   = 4'd6;
    localparam logic [3:0] S_SC_RD  = 4'd7;
    localparam logic [3:0] S_SC_CHK = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    logic [3:0]         r_state;
    logic [LIMIT_W-1:0] r_limit_n;
    logic [LIM_W-1:0]   r_lim;
    logic               r_ready;
    logic [LIM_W-1:0]   r_scan;
    logic [LIM_W-1:0]   r_k;
    logic [LIM_W-1:0]   r_p;
    logic [SQ_W-1:0]    r_sq;
    logic [SQ_W-1:0]    r_m;
    logic [LIM_W-1:0]   r_prime;
    logic               r_phase;
    logic               r_found;
    logic               r_last;
    logic               r_out_valid;
    logic [PRIME_W-1:0] r_out_data;
    logic               r_out_found;
    logic               r_out_last;

    logic               w_in_xfer;
    logic               w_cfg_wr;
    logic [CMP_W-1:0]   w_lim_ext;
    logic [LIM_W-1:0]   w_lim_clamp;
    logic [SQ_W-1:0]    w_lim_wide;
    logic [SQ_W-1:0]    w_add_a;
    logic [SQ_W-1:0]    w_add_b;
    logic [SQ_W-1:0]    w_sum;
    logic               w_we;
    logic [SQ_W-1:0]    w_wr_pos;
    logic               w_wdata;
    logic [ADDR_W-1:0]  w_raddr;
    logic               w_rdata;
    logic               w_emit;

    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign w_cfg_wr   = i_psel && i_penable && i_pwrite && o_pready
                        && (i_paddr[2] == REG_LIMIT_N);
    assign w_lim_ext  = CMP_W'(r_limit_n);
    assign w_lim_clamp = (w_lim_ext > CMP_W'(MAX_LIMIT)) ? LIM_W'(MAX_LIMIT)
                                                         : LIM_W'(w_lim_ext);
    assign w_lim_wide = SQ_W'(r_lim);

    // shared adder: counters, multiple stepping and the running square
    always_comb begin
        case (r_state)
            S_STRIKE: begin
                w_add_a = r_m;
                w_add_b = SQ_W'(r_p);
            end
            S_SV_SQ: begin
                w_add_a = r_sq;
                w_add_b = {r_p, 1'b1};     // (p+1)^2 = p^2 + 2p + 1
            end
            S_SV_P: begin
                w_add_a = SQ_W'(r_p);
                w_add_b = SQ_W'(1);
            end
            default: begin
                w_add_a = SQ_W'(r_k);
                w_add_b = SQ_W'(1);
            end
        endcase
    end

    assign w_sum = w_add_a + w_add_b;

    // bitmap port control
    assign w_wr_pos = (r_state == S_CLR) ? SQ_W'(r_k) : r_m;
    assign w_we     = ((r_state == S_CLR) && (r_k < r_lim))
                      || ((r_state == S_STRIKE) && (r_m < w_lim_wide));
    assign w_wdata  = (r_state == S_CLR) ? (r_k < LIM_W'(2)) : 1'b1;
    assign w_raddr  = (r_state == S_SV_RD) ? r_p[ADDR_W-1:0] : r_k[ADDR_W-1:0];

    pse_ram #(
        .WIDTH (1),
        .DEPTH (MAX_LIMIT)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wr_pos[ADDR_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_emit = (r_state == S_EMIT) && (!r_out_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ready   <= 1'b0;
            r_scan    <= '0;
            r_lim     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        if (i_s_tdata[0]) begin
                            r_lim   <= w_lim_clamp;
                            r_ready <= 1'b1;
                            r_k     <= '0;
                            r_p     <= LIM_W'(2);
                            r_sq    <= SQ_W'(4);
                            r_state <= S_CLR;
                        end else if (!r_ready) begin
                            r_found <= 1'b0;
                            r_prime <= '0;
                            r_last  <= 1'b0;
                            r_state <= S_EMIT;
                        end else begin
                            r_k     <= r_scan;
                            r_phase <= 1'b0;
                            r_state <= S_SC_RD;
                        end
                    end
                end
                S_CLR: begin
                    if (r_k < r_lim) begin
                        r_k <= w_sum[LIM_W-1:0];
                    end else if (r_sq < w_lim_wide) begin
                        r_state <= S_SV_RD;
                    end else begin
                        r_k     <= LIM_W'(2);
                        r_phase <= 1'b0;
                        r_state <= S_SC_RD;
                    end
                end
                S_SV_RD: begin
                    r_state <= S_SV_CHK;
                end
                S_SV_CHK: begin
                    if (w_rdata) begin
                        r_state <= S_SV_SQ;
                    end else begin
                        r_m     <= r_sq;
                        r_state <= S_STRIKE;
                    end
                end
                S_STRIKE: begin
                    if (r_m < w_lim_wide) begin
                        r_m <= w_sum;
                    end else begin
                        r_state <= S_SV_SQ;
                    end
                end
                S_SV_SQ: begin
                    r_sq    <= w_sum;
                    r_state <= S_SV_P;
                end
                S_SV_P: begin
                    r_p <= w_sum[LIM_W-1:0];
                    if (r_sq < w_lim_wide) begin
                        r_state <= S_SV_RD;
                    end else begin
                        r_k     <= LIM_W'(2);
                        r_phase <= 1'b0;
                        r_state <= S_SC_RD;
                    end
                end
                S_SC_RD: begin
                    if (r_k < r_lim) begin
                        r_state <= S_SC_CHK;
                    end else begin
                        // ran off the end: no prime, or the found one is the last
                        r_found <= r_phase;
                        r_last  <= r_phase;
                        if (!r_phase) begin
                            r_prime <= '0;
                        end
                        r_scan  <= r_lim;
                        r_state <= S_EMIT;
                    end
                end
                S_SC_CHK: begin
                    if (!w_rdata && !r_phase) begin
                        r_prime <= r_k;
                        r_k     <= w_sum[LIM_W-1:0];
                        r_phase <= 1'b1;
                        r_state <= S_SC_RD;
                    end else if (!w_rdata) begin
                        // next prime seen; resume from it on the following request
                        r_found <= 1'b1;
                        r_last  <= 1'b0;
                        r_scan  <= r_k;
                        r_state <= S_EMIT;
                    end else begin
                        r_k     <= w_sum[LIM_W-1:0];
                        r_state <= S_SC_RD;
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data  <= PRIME_W'(r_prime);
            r_out_found <= r_found;
            r_out_last  <= r_last;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_n <= LIMIT_RST;
        end else if (w_cfg_wr) begin
            r_limit_n <= i_pwdata[LIMIT_W-1:0];
        end
    end

    assign o_prdata   = (i_paddr[2] == REG_LIMIT_N) ? APB_DATA_W'(r_limit_n)
                                                    : '0;
    assign o_pready   = 1'b1;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_found;
    assign o_m_tlast  = r_out_last;

    `PSE_ASSERT_NOW(a_wr_below_limit, w_we, w_wr_pos < w_lim_wide)
    `PSE_ASSERT_NEXT(a_busy_after_req, w_in_xfer, !o_s_tready)
    `PSE_ASSERT_NOW(a_empty_result, o_m_tvalid && !o_m_tuser[0],
                    (o_m_tdata == '0) && !o_m_tlast)
    `PSE_ASSERT_NOW(a_found_needs_sieve, o_m_tvalid && o_m_tuser[0],
                    r_ready && (CMP_W'(o_m_tdata) >= CMP_W'(2)))

endmodule

`default_nettype wire

[tb/sv/prime_stream_checker.sv]
module prime_stream_checker
    import pse_pkg::*;
#(
    parameter int MAX_LIMIT = MAX_LIMIT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    input  wire logic [7:0]            i_s_tdata,   // [0] restart
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    input  wire logic [15:0]           i_m_tdata,   // [15:0] prime_value
    input  wire logic [0:0]            i_m_tuser,   // [0] found
    input  wire logic                  i_m_tlast,   // is_last
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic [APB_ADDR_W-1:0] i_paddr,
    input  wire logic [APB_DATA_W-1:0] i_pwdata,
    input  wire logic [APB_DATA_W-1:0] i_prdata,
    input  wire logic                  i_pready,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [PRIME_W-1:0] value;
        logic               found;
        logic               last;
    } t_prime_result;

    bit                 composite_bits [MAX_LIMIT];
    logic [LIMIT_W-1:0] limit_reg   = LIMIT_RST;
    logic [LIMIT_W-1:0] sieve_end   = '0;
    logic [LIMIT_W-1:0] scan_ptr    = '0;
    bit                 sieve_built = 1'b0;
    t_prime_result      primes_due [$];
    int                 fails   = 0;
    int                 checked = 0;

    function automatic void note_fail(input string what);
        fails++;
        if (fails <= 10) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
    endfunction

    // first unmarked number at or above from, or the sieve end if none
    function automatic int first_open(input int from);
        int k;
        for (k = from; k < int'(sieve_end); k++) begin
            if (!composite_bits[k]) begin
                return k;
            end
        end
        return int'(sieve_end);
    endfunction

    function automatic void build_sieve_map();
        int lim;
        int k;
        int p;
        int m;
        lim = (int'(limit_reg) > MAX_LIMIT) ? MAX_LIMIT : int'(limit_reg);
        sieve_end = LIMIT_W'(lim);
        for (k = 0; k < lim; k++) begin
            composite_bits[k] = (k < 2);
        end
        if (lim > 2) begin
            for (p = 2; p * p <= lim - 1; p++) begin
                if (!composite_bits[p]) begin
                    for (m = p * p; m < lim; m += p) begin
                        composite_bits[m] = 1'b1;
                    end
                end
            end
        end
        sieve_built = 1'b1;
        scan_ptr    = LIMIT_W'(2);
    endfunction

    function automatic t_prime_result predict_prime(input bit rebuild);
        t_prime_result res;
        int            p;
        res = '0;
        if (rebuild) begin
            build_sieve_map();
        end
        if (!sieve_built) begin
            return res;
        end
        if (scan_ptr < 2) begin
            scan_ptr = LIMIT_W'(2);
        end
        p = first_open(int'(scan_ptr));
        if (p >= int'(sieve_end)) begin
            // exhausted: park at the end until the next restart
            scan_ptr = sieve_end;
            return res;
        end
        scan_ptr  = LIMIT_W'(p + 1);
        res.value = PRIME_W'(p);
        res.found = 1'b1;
        res.last  = (first_open(p + 1) >= int'(sieve_end));
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_prime_result want;
        t_prime_result got;
        if (!i_rst_n) begin
            limit_reg   = LIMIT_RST;
            sieve_end   = '0;
            scan_ptr    = '0;
            sieve_built = 1'b0;
            primes_due.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr[2] == REG_LIMIT_N) begin
                if (i_pwrite) begin
                    limit_reg = i_pwdata[LIMIT_W-1:0];
                end else if (i_prdata !== APB_DATA_W'(limit_reg)) begin
                    note_fail($sformatf("limit_n read: expected %0d, got %0h",
                                        limit_reg, i_prdata));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                primes_due.push_back(predict_prime(i_s_tdata[0]));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.value = i_m_tdata;
                got.found = i_m_tuser[0];
                got.last  = i_m_tlast;
                if (primes_due.size() == 0) begin
                    note_fail($sformatf("result with nothing due: value=%0d found=%b last=%b",
                                        got.value, got.found, got.last));
                end else begin
                    want = primes_due.pop_front();
                    checked++;
                    if (got !== want) begin
                        note_fail($sformatf(
                            "expected value=%0d found=%b last=%b, got value=%0d found=%b last=%b",
                            want.value, want.found, want.last,
                            got.value, got.found, got.last));
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= primes_due.size();
        o_checked    <= checked;
    end

endmodule

[tb/sv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pse_pkg::*;

    localparam int                    CYCLE_LIMIT  = 5_000_000;
    localparam int                    RANDOM_ITEMS = 1650;
    localparam int                    LONG_HOLD    = 2000;
    localparam int                    TAIL_CYCLES  = 50;
    localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR   = {REG_LIMIT_N, 2'b00};

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [7:0]            s_tdata  = '0;
    logic                  m_tready = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;

    logic                  s_tready;
    logic                  m_tvalid;
    logic [15:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fails;
    int pending;
    int checked;

    int cycles     = 0;
    int burst_left = 0;
    bit no_idle    = 1'b0;
    int hold_reqs  = 0;
    int hold_done  = 0;
    int n_sent     = 0;
    int n_restarts = 0;
    int cur_limit  = int'(LIMIT_RST);
    int lim_min    = int'(LIMIT_RST);
    int lim_max    = int'(LIMIT_RST);

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    prime_sieve_enumerator i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .o_pready   (pready)
    );

    prime_stream_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fails),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: changing stall pattern, plus a long hold-off on request
    initial begin : rx_pattern
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(posedge clk);
            if (hold_reqs != hold_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done++;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((mode_left % 8) < 5);
            endcase
        end
    end

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering and wait until every expected result has come back
    task automatic drain();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic set_limit(input logic [31:0] value);
        drain();
        apb_write(LIMIT_ADDR, value);
        apb_read(LIMIT_ADDR);
        cur_limit = int'(value[LIMIT_W-1:0]);
        if (cur_limit < lim_min) lim_min = cur_limit;
        if (cur_limit > lim_max) lim_max = cur_limit;
    endtask

    task automatic send_req(input bit restart);
        int gap;
        if (burst_left == 0) begin
            if (no_idle) begin
                gap = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                gap = $urandom_range(5, 30);
            end else begin
                gap = $urandom_range(0, 4);
            end
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        n_sent++;
        if (restart) n_restarts++;
    endtask

    initial begin : stimulus
        int lim;
        int k;
        int n;
        int random_start;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // requests before any sieve exists
        send_req(1'b0);
        send_req(1'b0);
        // reset value of the limit
        send_req(1'b1);
        send_req(1'b0);
        send_req(1'b0);

        // output held off while requests keep coming
        no_idle = 1'b1;
        hold_reqs++;
        send_req(1'b1);
        repeat (3) send_req(1'b0);
        no_idle = 1'b0;

        // limits that give no primes, and the smallest that gives one
        set_limit(32'd0);
        send_req(1'b1);
        send_req(1'b0);
        set_limit(32'd2);
        send_req(1'b1);
        set_limit(32'd3);
        send_req(1'b1);
        send_req(1'b0);
        send_req(1'b0);
        set_limit(32'd1);
        send_req(1'b1);

        // full bitmap, then a value far above it that gets clamped
        set_limit(32'd65536);
        send_req(1'b1);
        send_req(1'b0);
        send_req(1'b0);
        set_limit(32'hFFFF_FFFF);
        send_req(1'b1);
        send_req(1'b0);

        // a new limit takes effect only at the next restart
        set_limit(32'd30);
        send_req(1'b1);
        send_req(1'b0);
        set_limit(32'd10);
        repeat (3) send_req(1'b0);

        random_start = n_sent;
        while (n_sent - random_start < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) != 0) begin
                case ($urandom_range(0, 19))
                    0, 1, 2: lim = $urandom_range(0, 16);
                    3, 4:    lim = $urandom_range(401, 3000);
                    default: lim = $urandom_range(17, 400);
                endcase
                set_limit(32'(lim));
            end
            send_req(1'b1);
            // often runs past exhaustion; a stray restart now and then
            n = $urandom_range(0, cur_limit / 4 + 3);
            for (k = 0; k < n; k++) begin
                send_req($urandom_range(0, 15) == 0);
            end
            if ($urandom_range(0, 2) == 0) begin
                drain();
            end
        end

        no_idle = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d requests with %0d restarts, %0d results compared",
                 n_sent, n_restarts, checked);
        $display("limits from %0d to %0d incl. clamped and empty ones, long output stalls",
                 lim_min, lim_max);
        if (pending != 0) begin
            $display("%0d expected results never arrived", pending);
        end
        if (fails == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
